@@ src/gm_pkg.sv @@
package gm_pkg;

    localparam int MASK_LEN_DEF = 32;

    localparam logic [7:0] STAR_CHAR  = 8'd42;
    localparam logic [7:0] QMARK_CHAR = 8'd63;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_SUBJECT = 2'd1,
        OP_END     = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // One word handed from the input register to the execution logic.
    typedef struct packed {
        logic       fire;
        t_op        op;
        logic [7:0] ch;
    } t_exec;

endpackage

@@ src/gm_if.sv @@
interface gm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] character;

    modport source (output valid, output operation, output character, input ready);
    modport sink   (input valid, input operation, input character, output ready);
endinterface

interface gm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic mask_overflow;

    modport source (output valid, output matched, output mask_overflow, input ready);
    modport sink   (input valid, input matched, input mask_overflow, output ready);
endinterface

@@ src/gm_mask_store.sv @@
module gm_mask_store
    import gm_pkg::*;
#(
    parameter int MASK_LEN = MASK_LEN_DEF,
    parameter int LEN_W    = $clog2(MASK_LEN + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_exec               i_exec,
    output logic [MASK_LEN-1:0] o_star,
    output logic [MASK_LEN-1:0] o_hit,
    output logic [LEN_W-1:0]    o_len,
    output logic                o_ovf
);

    logic [7:0]       r_mask [MASK_LEN];
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_ovf;
    logic             n_ovf;
    logic             full;
    logic             wr_en;

    assign full  = (r_len == LEN_W'(MASK_LEN));
    assign wr_en = i_exec.fire && (i_exec.op == OP_APPEND) && !full;

    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        if (i_exec.fire) begin
            unique case (i_exec.op)
                OP_APPEND: begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_len = r_len + LEN_W'(1);
                    end
                end
                OP_CLEAR: begin
                    n_len = '0;
                    n_ovf = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
        end
    end

    // Entries need no reset: positions at or above the length are masked off below.
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < MASK_LEN; p++) begin
            if (wr_en && (r_len == LEN_W'(p))) begin
                r_mask[p] <= i_exec.ch;
            end
        end
    end

    always_comb begin
        for (int p = 0; p < MASK_LEN; p++) begin
            o_star[p] = (LEN_W'(p) < r_len) && (r_mask[p] == STAR_CHAR);
            o_hit[p]  = (LEN_W'(p) < r_len) && (r_mask[p] != STAR_CHAR)
                        && ((r_mask[p] == QMARK_CHAR) || (r_mask[p] == i_exec.ch));
        end
    end

    assign o_len = r_len;
    assign o_ovf = r_ovf;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MASK_LEN))
        else $error("mask length beyond capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> full)
        else $error("overflow flagged while the store has room");

endmodule

@@ src/gm_nfa.sv @@
module gm_nfa
    import gm_pkg::*;
#(
    parameter int MASK_LEN = MASK_LEN_DEF,
    parameter int LEN_W    = $clog2(MASK_LEN + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_exec               i_exec,
    input  logic [MASK_LEN-1:0] i_star,
    input  logic [MASK_LEN-1:0] i_hit,
    input  logic [LEN_W-1:0]    i_len,
    output logic                o_matched
);

    // Raw set of reached positions, kept before the star closure is applied.
    logic [MASK_LEN:0] r_act;
    logic [MASK_LEN:0] n_act;
    logic [MASK_LEN:0] star_ext;
    logic [MASK_LEN:0] seed;
    logic [MASK_LEN:0] run_sum;
    logic [MASK_LEN:0] closed;
    logic [MASK_LEN:0] stepped;

    // A set bit on a star carries through the following run of stars and lands
    // one past it, the same way an add ripples a carry through a run of ones.
    assign star_ext = {1'b0, i_star};
    assign seed     = {1'b0, r_act[MASK_LEN-1:0] & i_star};
    assign run_sum  = seed + star_ext;
    assign closed   = r_act | (run_sum ^ star_ext);

    assign stepped  = {1'b0, closed[MASK_LEN-1:0] & i_star}
                    | {closed[MASK_LEN-1:0] & i_hit, 1'b0};

    assign o_matched = closed[i_len];

    always_comb begin
        n_act = r_act;
        if (i_exec.fire) begin
            unique case (i_exec.op)
                OP_SUBJECT: n_act = stepped;
                OP_APPEND,
                OP_END,
                OP_CLEAR:   n_act = (MASK_LEN + 1)'(1);
                default:    n_act = r_act;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= (MASK_LEN + 1)'(1);
        end else begin
            r_act <= n_act;
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec.fire && (i_exec.op != OP_SUBJECT)) |=> (r_act == (MASK_LEN + 1)'(1)))
        else $error("match state not restarted after a mask edit or end of subject");

endmodule

@@ src/wildcard_glob_matcher_top.sv @@
// Glob matcher for '*' and '?', case sensitive. Load the mask with append words (one byte
// each, up to MASK_LEN bytes; extra bytes are dropped and reported as overflow), then stream
// subject bytes and finish with an end-of-subject word, which returns one result word
// carrying matched and mask_overflow and restarts matching with the same mask. Appending or
// clearing the mask restarts any subject in progress. One word is accepted every cycle; the
// input stalls only while an end-of-subject word waits in the input register behind a result
// word that has not been taken. A result word is registered: an accepted end-of-subject word
// first moves into the input register, and when it executes, its result moves into the result
// register. The cycle time is set by the star closure, one carry chain across MASK_LEN+1
// positions, alongside the per-position byte compare. No clearing pass is needed after
// reset.
module wildcard_glob_matcher_top
    import gm_pkg::*;
#(
    parameter int MASK_LEN = MASK_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gm_in_if.sink     i_in,
    gm_out_if.source  o_out
);

    localparam int LEN_W = $clog2(MASK_LEN + 1);

    logic                r_in_v;
    t_op                 r_in_op;
    logic [7:0]          r_in_ch;
    logic                r_out_v;
    logic                r_out_matched;
    logic                r_out_ovf;
    logic                stall;
    t_exec               exec;
    logic [MASK_LEN-1:0] star;
    logic [MASK_LEN-1:0] hit;
    logic [LEN_W-1:0]    len;
    logic                ovf;
    logic                matched;

    // Only an end-of-subject word waits, and only while the previous result is unread.
    assign stall = r_in_v && (r_in_op == OP_END) && r_out_v && !o_out.ready;

    assign i_in.ready = !stall;

    assign exec.fire = r_in_v && !stall;
    assign exec.op   = r_in_op;
    assign exec.ch   = r_in_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (!stall) begin
            r_in_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_in_op <= t_op'(i_in.operation);
            r_in_ch <= i_in.character;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (exec.fire && (exec.op == OP_END)) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec.fire && (exec.op == OP_END)) begin
            r_out_matched <= matched;
            r_out_ovf     <= ovf;
        end
    end

    gm_mask_store #(
        .MASK_LEN (MASK_LEN),
        .LEN_W    (LEN_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (exec),
        .o_star  (star),
        .o_hit   (hit),
        .o_len   (len),
        .o_ovf   (ovf)
    );

    gm_nfa #(
        .MASK_LEN (MASK_LEN),
        .LEN_W    (LEN_W)
    ) u_nfa (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_exec    (exec),
        .i_star    (star),
        .i_hit     (hit),
        .i_len     (len),
        .o_matched (matched)
    );

    assign o_out.valid         = r_out_v;
    assign o_out.matched       = r_out_matched;
    assign o_out.mask_overflow = r_out_ovf;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec.fire && (exec.op == OP_END)) |=> r_out_v)
        else $error("end of subject executed without a result word");

endmodule
